FILE: hdl/fpp_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fpp_pkg: shared types and constants of the framed packet parser
// phase codes, status and kind codes, register indexes, crc-8 update
// ----------------------------------------------------------------------------
package fpp_pkg;

   localparam int BYTE_W    = 8;
   localparam int TICK_W    = 16;
   localparam int STATUS_W  = 2;
   localparam int CSR_IDX_W = 3;
   localparam int CSR_DAT_W = 16;

   localparam logic [BYTE_W-1:0] CRC_POLY = 8'h07;
   localparam logic [BYTE_W-1:0] CRC_MSB  = 8'h80;

   // register reset values
   localparam logic [BYTE_W-1:0] START_MARKER_RST  = 8'd2;
   localparam logic [BYTE_W-1:0] END_MARKER_RST    = 8'd3;
   localparam logic [BYTE_W-1:0] BASE_KEY_RST      = 8'd0;
   localparam logic [BYTE_W-1:0] MAX_PAYLOAD_RST   = 8'd120;
   localparam logic [TICK_W-1:0] TIMEOUT_TICKS_RST = 16'd500;

   localparam logic [TICK_W-1:0] TICK_MAX = '1;

   // register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_START_MARKER  = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_END_MARKER    = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_BASE_KEY      = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_MAX_PAYLOAD   = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_TIMEOUT_TICKS = 3'd4;

   // request op codes
   localparam logic OP_BYTE = 1'b0;
   localparam logic OP_TICK = 1'b1;

   // result kinds
   localparam logic KIND_PAYLOAD   = 1'b0;
   localparam logic KIND_FRAME_END = 1'b1;

   // frame end status
   localparam logic [STATUS_W-1:0] ST_OK      = 2'd0;
   localparam logic [STATUS_W-1:0] ST_CRC_BAD = 2'd1;
   localparam logic [STATUS_W-1:0] ST_ETX_BAD = 2'd2;
   localparam logic [STATUS_W-1:0] ST_TIMEOUT = 2'd3;

   typedef enum logic [6:0] {
      PH_IDLE    = 7'b0000001,
      PH_CMD     = 7'b0000010,
      PH_SALT    = 7'b0000100,
      PH_LEN     = 7'b0001000,
      PH_PAYLOAD = 7'b0010000,
      PH_CRC     = 7'b0100000,
      PH_ETX     = 7'b1000000
   } phase_type;

   typedef struct packed {
      logic [BYTE_W-1:0] start_marker;
      logic [BYTE_W-1:0] end_marker;
      logic [BYTE_W-1:0] base_key;
      logic [BYTE_W-1:0] max_payload;
      logic [TICK_W-1:0] timeout_ticks;
   } cfg_type;

   typedef struct packed {
      logic                op;
      logic [BYTE_W-1:0]   rx_data;
   } item_type;

   typedef struct packed {
      logic                kind;
      logic [BYTE_W-1:0]   payload_byte;
      logic [BYTE_W-1:0]   byte_index;
      logic [BYTE_W-1:0]   command;
      logic [BYTE_W-1:0]   frame_length;
      logic [STATUS_W-1:0] status;
   } result_type;

   // crc-8, msb first, one byte
   function automatic logic [BYTE_W-1:0] crc8_byte(input logic [BYTE_W-1:0] crc,
                                                   input logic [BYTE_W-1:0] b);
      logic [BYTE_W-1:0] c;
      c = crc ^ b;
      for (int k = 0; k < BYTE_W; k++) begin
         if ((c & CRC_MSB) != '0) begin
            c = (c << 1) ^ CRC_POLY;
         end else begin
            c = c << 1;
         end
      end
      return c;
   endfunction

endpackage

FILE: hdl/fpp_intf.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fpp_intf: channel interfaces of the framed packet parser
// request, response and register write channels with valid/ready
// ----------------------------------------------------------------------------
interface fpp_req_if
   import fpp_pkg::*;
();
   logic              valid;
   logic              ready;
   logic              op;
   logic [BYTE_W-1:0] rx_data;

   modport source (output valid, op, rx_data, input ready);
   modport sink   (input valid, op, rx_data, output ready);
endinterface

interface fpp_rsp_if
   import fpp_pkg::*;
();
   logic                valid;
   logic                ready;
   logic                kind;
   logic [BYTE_W-1:0]   payload_byte;
   logic [BYTE_W-1:0]   byte_index;
   logic [BYTE_W-1:0]   command;
   logic [BYTE_W-1:0]   frame_length;
   logic [STATUS_W-1:0] status;

   modport source (output valid, kind, payload_byte, byte_index, command,
                   frame_length, status, input ready);
   modport sink   (input valid, kind, payload_byte, byte_index, command,
                   frame_length, status, output ready);
endinterface

interface fpp_csr_if
   import fpp_pkg::*;
();
   logic                 valid;
   logic                 ready;
   logic [CSR_IDX_W-1:0] index;
   logic [CSR_DAT_W-1:0] data;

   modport source (output valid, index, data, input ready);
   modport sink   (input valid, index, data, output ready);
endinterface

FILE: hdl/fpp_csr.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fpp_csr: configuration registers
// takes register writes, always ready, unknown indexes ignored
// ----------------------------------------------------------------------------
module fpp_csr
   import fpp_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   fpp_csr_if.sink csr_if,
   output cfg_type cfg
);

   cfg_type cfg_ff;
   cfg_type cfg_in;

   assign csr_if.ready = 1'b1;
   assign cfg          = cfg_ff;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_if.valid) begin
         unique case (csr_if.index)
            CSR_START_MARKER:  cfg_in.start_marker  = csr_if.data[BYTE_W-1:0];
            CSR_END_MARKER:    cfg_in.end_marker    = csr_if.data[BYTE_W-1:0];
            CSR_BASE_KEY:      cfg_in.base_key      = csr_if.data[BYTE_W-1:0];
            CSR_MAX_PAYLOAD:   cfg_in.max_payload   = csr_if.data[BYTE_W-1:0];
            CSR_TIMEOUT_TICKS: cfg_in.timeout_ticks = csr_if.data[TICK_W-1:0];
            default:           cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.start_marker  <= START_MARKER_RST;
         cfg_ff.end_marker    <= END_MARKER_RST;
         cfg_ff.base_key      <= BASE_KEY_RST;
         cfg_ff.max_payload   <= MAX_PAYLOAD_RST;
         cfg_ff.timeout_ticks <= TIMEOUT_TICKS_RST;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

endmodule

FILE: hdl/fpp_parser.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fpp_parser: frame state machine
// advances one item per step, keeps crc and session key, builds the result
// ----------------------------------------------------------------------------
module fpp_parser
   import fpp_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  cfg_type    cfg,
   input  logic       step,
   input  item_type   item,
   output logic       res_valid,
   output result_type res
);

   phase_type         phase_ff,   phase_in;
   logic [BYTE_W-1:0] cmd_ff,     cmd_in;
   logic [BYTE_W-1:0] key_ff,     key_in;
   logic [BYTE_W-1:0] length_ff,  length_in;
   logic [BYTE_W-1:0] index_ff,   index_in;
   logic [BYTE_W-1:0] crc_ff,     crc_in;
   logic [BYTE_W-1:0] crc_rx_ff,  crc_rx_in;
   logic [TICK_W-1:0] idle_ff,    idle_in;

   logic [BYTE_W-1:0] crc_next;
   logic [BYTE_W:0]   index_inc;
   logic [TICK_W-1:0] idle_inc;

   assign crc_next  = crc8_byte(crc_ff, item.rx_data);
   assign index_inc = {1'b0, index_ff} + 1'b1;
   assign idle_inc  = (idle_ff == TICK_MAX) ? idle_ff : idle_ff + 1'b1;

   always_comb begin
      phase_in  = phase_ff;
      cmd_in    = cmd_ff;
      key_in    = key_ff;
      length_in = length_ff;
      index_in  = index_ff;
      crc_in    = crc_ff;
      crc_rx_in = crc_rx_ff;
      idle_in   = idle_ff;

      res_valid        = 1'b0;
      res.kind         = KIND_PAYLOAD;
      res.payload_byte = '0;
      res.byte_index   = '0;
      res.command      = cmd_ff;
      res.frame_length = length_ff;
      res.status       = ST_OK;

      if (item.op == OP_TICK) begin
         if (phase_ff != PH_IDLE) begin
            idle_in = idle_inc;
            if (idle_inc > cfg.timeout_ticks) begin
               phase_in   = PH_IDLE;
               res_valid  = 1'b1;
               res.kind   = KIND_FRAME_END;
               res.status = ST_TIMEOUT;
            end
         end
      end else begin
         idle_in = '0;
         unique case (phase_ff)
            PH_IDLE: begin
               if (item.rx_data == cfg.start_marker) begin
                  cmd_in    = '0;
                  length_in = '0;
                  index_in  = '0;
                  key_in    = '0;
                  crc_in    = '0;
                  phase_in  = PH_CMD;
               end
            end
            PH_CMD: begin
               cmd_in   = item.rx_data;
               crc_in   = crc_next;
               phase_in = PH_SALT;
            end
            PH_SALT: begin
               key_in   = cfg.base_key ^ item.rx_data;
               crc_in   = crc_next;
               phase_in = PH_LEN;
            end
            PH_LEN: begin
               crc_in   = crc_next;
               index_in = '0;
               if (item.rx_data > cfg.max_payload) begin
                  // oversize frame is dropped silently
                  phase_in = PH_IDLE;
               end else begin
                  length_in = item.rx_data;
                  phase_in  = (item.rx_data == '0) ? PH_CRC : PH_PAYLOAD;
               end
            end
            PH_PAYLOAD: begin
               crc_in           = crc_next;
               res_valid        = 1'b1;
               res.payload_byte = item.rx_data ^ (key_ff + index_ff);
               res.byte_index   = index_ff;
               index_in         = index_inc[BYTE_W-1:0];
               if (index_inc >= {1'b0, length_ff}) begin
                  phase_in = PH_CRC;
               end
            end
            PH_CRC: begin
               crc_rx_in = item.rx_data;
               phase_in  = PH_ETX;
            end
            PH_ETX: begin
               phase_in  = PH_IDLE;
               res_valid = 1'b1;
               res.kind  = KIND_FRAME_END;
               if (item.rx_data != cfg.end_marker) begin
                  res.status = ST_ETX_BAD;
               end else if (crc_ff == crc_rx_ff) begin
                  res.status = ST_OK;
               end else begin
                  res.status = ST_CRC_BAD;
               end
            end
            default: phase_in = PH_IDLE;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff  <= PH_IDLE;
         cmd_ff    <= '0;
         key_ff    <= '0;
         length_ff <= '0;
         index_ff  <= '0;
         crc_ff    <= '0;
         crc_rx_ff <= '0;
         idle_ff   <= '0;
      end else if (step) begin
         phase_ff  <= phase_in;
         cmd_ff    <= cmd_in;
         key_ff    <= key_in;
         length_ff <= length_in;
         index_ff  <= index_in;
         crc_ff    <= crc_in;
         crc_rx_ff <= crc_rx_in;
         idle_ff   <= idle_in;
      end
   end

endmodule

FILE: hdl/framed_packet_parser_crc8_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// framed_packet_parser_crc8_top: byte-serial frame parser with crc-8
// start, command, salt, length, payload, crc, end marker deframing
// ----------------------------------------------------------------------------
// usage
//   req channel: one request per byte (op 0) or per timer tick (op 1)
//   rsp channel: descrambled payload bytes (kind 0) and frame end reports
//     (kind 1) with status ok, crc mismatch, bad end marker or timeout;
//     payload bytes of a frame whose report is not ok are to be discarded
//   csr channel: register writes by index, always ready; write only while
//     the parser holds no request and no response is pending
// throughput: one request per cycle while the response register is free to
//   take a result; the frame state machine and the crc byte update are
//   combinational between the request register and the response register
// path: an accepted request loads the request register; its result, if it has
//   one, loads the response register when the parser steps on that request
// reset: synchronous; registers return to their defaults, the parser goes
//   idle and both pipeline registers are emptied
// stall: while rsp.ready is low the response register holds; one more
//   request may wait in the request register, then req.ready drops
// ----------------------------------------------------------------------------
module framed_packet_parser_crc8_top
   import fpp_pkg::*;
(
   input  logic      clock,
   input  logic      reset,
   fpp_req_if.sink   req_if,
   fpp_rsp_if.source rsp_if,
   fpp_csr_if.sink   csr_if
);

   cfg_type    cfg;

   // request register
   logic       req_vld_ff;
   item_type   req_ff;

   // response register
   logic       rsp_vld_ff;
   result_type rsp_ff;

   // parser outputs
   logic       res_valid;
   result_type res;

   logic       step;
   logic       rsp_free;

   // response register can take a new value when empty or being drained
   assign rsp_free = !rsp_vld_ff || rsp_if.ready;
   // the held request is parsed when its result has a place to go
   assign step     = req_vld_ff && rsp_free;

   assign req_if.ready = !req_vld_ff || step;

   fpp_csr u_csr (
      .clock  (clock),
      .reset  (reset),
      .csr_if (csr_if),
      .cfg    (cfg)
   );

   fpp_parser u_parser (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg),
      .step      (step),
      .item      (req_ff),
      .res_valid (res_valid),
      .res       (res)
   );

   // request stage
   always_ff @(posedge clock) begin
      if (reset) begin
         req_vld_ff <= 1'b0;
      end else if (req_if.ready) begin
         req_vld_ff <= req_if.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_if.valid && req_if.ready) begin
         req_ff.op      <= req_if.op;
         req_ff.rx_data <= req_if.rx_data;
      end
   end

   // response stage; requests without a result leave it untouched
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_vld_ff <= 1'b0;
      end else if (rsp_free) begin
         rsp_vld_ff <= step && res_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (step && res_valid) begin
         rsp_ff <= res;
      end
   end

   assign rsp_if.valid        = rsp_vld_ff;
   assign rsp_if.kind         = rsp_ff.kind;
   assign rsp_if.payload_byte = rsp_ff.payload_byte;
   assign rsp_if.byte_index   = rsp_ff.byte_index;
   assign rsp_if.command      = rsp_ff.command;
   assign rsp_if.frame_length = rsp_ff.frame_length;
   assign rsp_if.status       = rsp_ff.status;

endmodule
